[src/lse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// Shared constants and controller/datapath interface types for the
// log series evaluator.
// ----------------------------------------------------------------------------
package lse_pkg;

   // default parameter values
   localparam int DEF_MAX_TERMS = 64;
   localparam int DEF_FRAC_BITS = 14;

   // configuration register file
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam int CFG_BITS      = 7;

   localparam logic [CSR_IDX_BITS-1:0] REG_TERM_COUNT = 1'b0;
   localparam logic [CFG_BITS-1:0]     TERM_RESET     = 7'd16;

   // controller to datapath
   typedef struct packed {
      logic load;       // take the argument, set up u, sum and term index
      logic mul;        // register the power times u
      logic div_load;   // floor shift, saturate, start the divider
      logic div_step;   // one restoring divide step
      logic acc;        // add or subtract the term, next term index
      logic emit;       // move the sum into the output register
   } lse_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic term_pending;  // term index within the term count
      logic last_term;     // current term index is the last one
      logic out_free;      // output register may be loaded
   } lse_stat_type;

endpackage
`default_nettype wire

[src/log_series_evaluator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_series_evaluator_unit
// Natural log of an unsigned fixed-point argument by the series in u = x - 1,
// summed over a configurable number of terms.
// ----------------------------------------------------------------------------
// per item: the first term u is set up on accept, then terms 2 to N, with
//   N = min(term_count, MAX_TERMS), each run a multiply, a floor shift and
//   saturate, FRAC_BITS + 2 restoring divide steps and an accumulate
// one item in flight: a new item is not taken until the result has moved
//   into the output register
// the next item is taken while the previous result waits in the output register
// reset: synchronous, active high; term_count returns to 16, no clearing pass
// ----------------------------------------------------------------------------
module log_series_evaluator_unit #(
   parameter int MAX_TERMS = lse_pkg::DEF_MAX_TERMS,
   parameter int FRAC_BITS = lse_pkg::DEF_FRAC_BITS,
   localparam int IN_TW  = ((FRAC_BITS + 2 + 7) / 8) * 8,
   localparam int OUT_TW = ((FRAC_BITS + 6 + 7) / 8) * 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // input items
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [IN_TW-1:0]                     req_tdata,   // x_value, zero pad
   // result items
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [OUT_TW-1:0]                    rsp_tdata,   // ln_approx, zero pad
   // configuration
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [lse_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire  [lse_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [lse_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int IN_BITS  = FRAC_BITS + 2;
   localparam int OUT_BITS = FRAC_BITS + 6;

   // register file: term_count only
   logic [lse_pkg::CFG_BITS-1:0]     term_count_ff;
   logic [lse_pkg::CSR_IDX_BITS-1:0] csr_idx;
   logic                             csr_wr;

   assign csr_idx    = csr_paddr[lse_pkg::CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= lse_pkg::TERM_RESET;
      end else if (csr_wr && (csr_idx == lse_pkg::REG_TERM_COUNT)) begin
         term_count_ff <= csr_pwdata[lse_pkg::CFG_BITS-1:0];
      end
   end

   // reads of unknown registers return zero
   always_comb begin
      csr_prdata = '0;
      if (csr_idx == lse_pkg::REG_TERM_COUNT) begin
         csr_prdata = lse_pkg::CSR_DATA_BITS'(term_count_ff);
      end
   end

   // controller <-> datapath
   lse_pkg::lse_cmd_type  cmd;
   lse_pkg::lse_stat_type stat;

   logic signed [OUT_BITS-1:0] ln_approx;

   lse_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lse_dpath #(
      .MAX_TERMS (MAX_TERMS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .x_value    (req_tdata[IN_BITS-1:0]),
      .term_count (term_count_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .ln_approx  (ln_approx)
   );

   // result packed from bit 0, upper bits zero
   assign rsp_tdata = OUT_TW'($unsigned(ln_approx));

endmodule
`default_nettype wire

[src/lse_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_ctrl
// Sequencer that steps the datapath through multiply, divide and accumulate
// for every series term after the first.
// ----------------------------------------------------------------------------
module lse_ctrl #(
   parameter int FRAC_BITS = lse_pkg::DEF_FRAC_BITS
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  lse_pkg::lse_stat_type stat,
   output lse_pkg::lse_cmd_type  cmd
);

   localparam int DW = FRAC_BITS + 2;
   localparam int CW = $clog2(DW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIVLD = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_ACC   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = stat.term_pending ? S_MUL : S_DONE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIVLD;
         end
         S_DIVLD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               state_in = S_ACC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.last_term ? S_DONE : S_MUL;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[src/lse_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_dpath
// Power register with shared multiplier, restoring divider by the term
// index, saturating accumulator and output register.
// ----------------------------------------------------------------------------
module lse_dpath #(
   parameter int MAX_TERMS = lse_pkg::DEF_MAX_TERMS,
   parameter int FRAC_BITS = lse_pkg::DEF_FRAC_BITS
) (
   input  wire                          clock,
   input  wire                          reset,
   input  lse_pkg::lse_cmd_type         cmd,
   output lse_pkg::lse_stat_type        stat,
   input  wire  [FRAC_BITS+1:0]         x_value,
   input  wire  [lse_pkg::CFG_BITS-1:0] term_count,
   input  wire                          rsp_tready,
   output logic                         rsp_tvalid,
   output logic signed [FRAC_BITS+5:0]  ln_approx
);

   localparam int IN_BITS = FRAC_BITS + 2;
   localparam int PW      = FRAC_BITS + 2;   // power, signed Q1.F
   localparam int PRODW   = 2 * PW;
   localparam int SHW     = PRODW - FRAC_BITS;
   localparam int SW      = FRAC_BITS + 6;   // sum, signed Q5.F
   localparam int DW      = PW;              // divider dividend magnitude
   localparam int KW      = $clog2(MAX_TERMS + 1);

   localparam logic [IN_BITS:0] ONE_U = {{(IN_BITS - FRAC_BITS){1'b0}}, 1'b1,
                                         {FRAC_BITS{1'b0}}};
   localparam logic signed [PW:0]    U_HI  = {2'b00, {(PW-1){1'b1}}};
   localparam logic signed [PW:0]    U_LO  = {2'b11, {(PW-1){1'b0}}};
   localparam logic signed [PW-1:0]  P_HI  = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0]  P_LO  = {1'b1, {(PW-1){1'b0}}};
   localparam logic signed [SHW-1:0] SH_HI = {3'b000, {(PW-1){1'b1}}};
   localparam logic signed [SHW-1:0] SH_LO = {3'b111, {(PW-1){1'b0}}};
   localparam logic signed [SW:0]    S_HI  = {2'b00, {(SW-1){1'b1}}};
   localparam logic signed [SW:0]    S_LO  = {2'b11, {(SW-1){1'b0}}};

   logic signed [PW-1:0]    us_ff;
   logic signed [PW-1:0]    p_ff;
   logic signed [PRODW-1:0] prod_ff;
   logic signed [SW-1:0]    sum_ff;
   logic [KW:0]             k_ff;
   logic [KW-1:0]           n_ff;
   logic [DW-1:0]           quo_ff;
   logic [KW-1:0]           rem_ff;
   logic                    neg_ff;
   logic                    rsp_valid_ff;
   logic signed [SW-1:0]    rsp_data_ff;

   // argument setup
   logic signed [IN_BITS:0] u_w;
   logic signed [PW-1:0]    us_w;
   logic [31:0]             tc_w;
   logic [KW-1:0]           n_w;

   assign u_w  = $signed({1'b0, x_value}) - $signed(ONE_U);
   assign us_w = (u_w > U_HI) ? P_HI : (u_w < U_LO) ? P_LO : u_w[PW-1:0];
   assign tc_w = 32'(term_count);
   assign n_w  = (tc_w > 32'(MAX_TERMS)) ? KW'(MAX_TERMS) : KW'(tc_w);

   // floor shift of the product and saturation to Q1.F
   logic signed [SHW-1:0] sh_w;
   logic signed [PW-1:0]  p_w;
   logic [DW-1:0]         mag_w;

   assign sh_w  = prod_ff[PRODW-1:FRAC_BITS];
   assign p_w   = (sh_w > SH_HI) ? P_HI : (sh_w < SH_LO) ? P_LO : sh_w[PW-1:0];
   assign mag_w = p_w[PW-1] ? DW'(~p_w + 1'b1) : DW'(p_w);

   // restoring divide step
   logic [KW:0]   shl_w;
   logic [KW+1:0] diff_w;

   assign shl_w  = {rem_ff, quo_ff[DW-1]};
   assign diff_w = {1'b0, shl_w} - {2'b00, k_ff[KW-1:0]};

   // accumulate with saturation
   logic signed [SW:0] q_ext_w;
   logic signed [SW:0] acc_w;
   logic signed [SW:0] sum_ext_w;
   logic               sub_w;

   assign q_ext_w   = $signed({{(SW + 1 - DW){1'b0}}, quo_ff});
   assign sum_ext_w = {sum_ff[SW-1], sum_ff};
   assign sub_w     = neg_ff ^ ~k_ff[0];
   assign acc_w     = sub_w ? (sum_ext_w - q_ext_w) : (sum_ext_w + q_ext_w);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         us_ff  <= us_w;
         p_ff   <= us_w;
         sum_ff <= {{(SW - IN_BITS - 1){u_w[IN_BITS]}}, u_w};
         k_ff   <= (KW+1)'(2);
         n_ff   <= n_w;
      end
      if (cmd.mul) begin
         prod_ff <= p_ff * us_ff;
      end
      if (cmd.div_load) begin
         p_ff   <= p_w;
         quo_ff <= mag_w;
         neg_ff <= p_w[PW-1];
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!diff_w[KW+1]) begin
            rem_ff <= diff_w[KW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= shl_w[KW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
      end
      if (cmd.acc) begin
         sum_ff <= (acc_w > S_HI) ? S_HI[SW-1:0] :
                   (acc_w < S_LO) ? S_LO[SW-1:0] : acc_w[SW-1:0];
         k_ff   <= k_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_data_ff <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.term_pending = (k_ff <= {1'b0, n_ff});
   assign stat.last_term    = (k_ff >= {1'b0, n_ff});
   assign stat.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign ln_approx  = rsp_data_ff;

   // divisor stays a real term index while dividing
   a_div_index: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (k_ff >= (KW+1)'(2)) && (k_ff <= {1'b0, n_ff}))
      else $error("divide step with term index out of range");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("output register overwritten before it was taken");

   a_acc_next: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |=> k_ff == $past(k_ff) + 1'b1)
      else $error("term index did not advance after accumulate");

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the log series evaluator. It sends x arguments over
// the input stream at a range of term counts, predicts or takes from the table
// every series sum in fixed point, and compares each result item in order. Both sides idle at
// random, and twice the result side holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module testbench;

   // fixed-point layout at the default parameters
   localparam int     FRAC      = lse_pkg::DEF_FRAC_BITS;
   localparam int     TERMS_CAP = lse_pkg::DEF_MAX_TERMS;
   localparam longint ONE       = longint'(1) << FRAC;
   localparam longint POW_HI    = (longint'(1) << (FRAC + 1)) - 1;
   localparam longint POW_LO    = -(longint'(1) << (FRAC + 1));
   localparam longint SUM_HI    = (longint'(1) << (FRAC + 5)) - 1;
   localparam longint SUM_LO    = -(longint'(1) << (FRAC + 5));

   localparam int AW = lse_pkg::CSR_ADDR_BITS;
   localparam int DW = lse_pkg::CSR_DATA_BITS;

   // run control
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int TAIL_CYCLES = 1300;       // tail wait for any results still due
   localparam int HOLD_CYCLES = 250;        // long result stall
   localparam int MAX_REPORTS = 10;

   // register map: term count at index 0, index 1 has no register
   localparam logic [AW-1:0] ADDR_TERM_COUNT = {lse_pkg::REG_TERM_COUNT, 2'b00};
   localparam logic [AW-1:0] ADDR_SPARE      = {~lse_pkg::REG_TERM_COUNT, 2'b00};

   // one row of the directed table
   typedef struct packed {
      logic [6:0]         terms;   // term count for this row
      logic [15:0]        x;       // argument, Q2.14
      logic               fixed;   // expected sum typed in below
      logic signed [19:0] ln;      // typed expected sum, Q5.14
   } dir_row_type;

   // one pending result
   typedef struct {
      logic [15:0] x;
      logic [6:0]  terms;
      logic [23:0] tdata;
   } ln_expect_type;

   localparam int NUM_DIR    = 22;
   localparam int NUM_PHASES = 10;

   // clock, reset and block ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // x_value[15:0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // ln_approx[19:0], zero pad[23:20]

   logic          csr_psel    = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite  = 1'b0;
   logic [AW-1:0] csr_paddr   = '0;
   logic [DW-1:0] csr_pwdata  = '0;
   logic [DW-1:0] csr_prdata;
   logic          csr_pready;

   // bench state
   ln_expect_type ln_expect_q [$];
   logic [6:0]    term_setting = lse_pkg::TERM_RESET;  // mirror of the term count register
   int            fail_count   = 0;
   int            cycle_count  = 0;
   bit            idle_en      = 1'b1;
   bit            hold_off_req = 1'b0;

   // directed rows: extremes of x, of the term count, and the corner cases
   dir_row_type dir_rows [NUM_DIR] = '{
      '{7'd16,  16'd16384, 1'b1, 20'sd0},        // u = 0 right after reset
      '{7'd16,  16'd0,     1'b0, 20'sd0},
      '{7'd16,  16'd32768, 1'b0, 20'sd0},
      '{7'd16,  16'd65535, 1'b0, 20'sd0},        // beyond 2.0, u saturates in powers
      '{7'd16,  16'd1,     1'b0, 20'sd0},
      '{7'd0,   16'd0,     1'b1, -20'sd16384},   // few terms: u alone
      '{7'd0,   16'd32768, 1'b1, 20'sd16384},
      '{7'd0,   16'd65535, 1'b1, 20'sd49151},    // u kept whole for term one
      '{7'd1,   16'd12345, 1'b1, -20'sd4039},
      '{7'd1,   16'd16384, 1'b1, 20'sd0},
      '{7'd2,   16'd0,     1'b0, 20'sd0},
      '{7'd2,   16'd32767, 1'b0, 20'sd0},
      '{7'd64,  16'd0,     1'b0, 20'sd0},
      '{7'd64,  16'd32768, 1'b0, 20'sd0},
      '{7'd64,  16'd65535, 1'b0, 20'sd0},
      '{7'd64,  16'd16384, 1'b1, 20'sd0},
      '{7'd127, 16'd8192,  1'b0, 20'sd0},        // too many terms, capped
      '{7'd127, 16'd16384, 1'b1, 20'sd0},
      '{7'd65,  16'd40000, 1'b0, 20'sd0},
      '{7'd3,   16'd24576, 1'b0, 20'sd0},
      '{7'd3,   16'd16383, 1'b0, 20'sd0},
      '{7'd3,   16'd16385, 1'b0, 20'sd0}
   };

   // random phases: term count (-1 picks one at random) and item count
   int phase_terms [NUM_PHASES] = '{2, 64, 0, 127, 5, 16, 1, 65, -1, 9};
   int phase_items [NUM_PHASES] = '{60, 25, 60, 20, 70, 60, 50, 20, 70, 65};

   log_series_evaluator_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // series predictor
   // ---------------------------------------------------------------------
   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // ln(x) ~ u - u^2/2 + u^3/3 - ..., powers kept in Q1.14, sum in Q5.14
   function automatic logic [19:0] ln_series(input logic [15:0] x, input logic [6:0] terms);
      longint u;
      longint u_sat;
      longint pw;
      longint acc;
      longint term;
      int     n;
      int     k;
      u     = longint'(x) - ONE;
      u_sat = clamp(u, POW_LO, POW_HI);
      pw    = u_sat;
      acc   = clamp(u, SUM_LO, SUM_HI);
      n     = (int'(terms) > TERMS_CAP) ? TERMS_CAP : int'(terms);
      for (k = 2; k <= n; k++) begin
         // floor shift of the product, then back into Q1.14
         pw   = clamp((pw * u_sat) >>> FRAC, POW_LO, POW_HI);
         // divide truncates toward zero
         term = pw / longint'(k);
         if (k % 2 == 0) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
         acc = clamp(acc, SUM_LO, SUM_HI);
      end
      return acc[19:0];
   endfunction

   // mostly in range, some near 1.0, some beyond 2.0, a few exact extremes
   function automatic logic [15:0] rand_x();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) return 16'($urandom_range(0, 32768));
      if (pick < 17) return 16'($urandom_range(16384 - 512, 16384 + 512));
      if (pick < 19) return 16'($urandom_range(32769, 65535));
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'd16384;
         2: return 16'd32768;
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // ---------------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------------
   // offer one x item, record its expected sum once accepted
   task automatic push_x(input logic [15:0] x, input logic [23:0] tdata);
      ln_expect_type entry;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      entry.x     = x;
      entry.terms = term_setting;
      entry.tdata = tdata;
      ln_expect_q.push_back(entry);
   endtask

   // stop offering and wait for every pending result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ln_expect_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   // setup phase, then access phase until pready, then back to idle
   task automatic csr_access(input logic wr, input logic [AW-1:0] addr,
                             input logic [DW-1:0] wdata,
                             output logic [DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_term_count();
      logic [DW-1:0] rd;
      csr_access(1'b0, ADDR_TERM_COUNT, '0, rd);
      if (rd !== DW'(term_setting))
         note_failure($sformatf("term_count readback: expected %0d got %h",
                                term_setting, rd));
   endtask

   // write the term count with junk in the unused upper bits
   task automatic set_term_count(input logic [6:0] terms);
      logic [DW-1:0] rd;
      drain();
      csr_access(1'b1, ADDR_TERM_COUNT,
                 ($urandom() & 32'hFFFF_FF80) | DW'(terms), rd);
      term_setting = terms;
      check_term_count();
   endtask

   // ---------------------------------------------------------------------
   // result side pacing: random bursts of stall, plus on request a long hold-off
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            // input keeps offering while this counts down
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_en && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // result check against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      ln_expect_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ln_expect_q.size() == 0) begin
            note_failure($sformatf("result %h with no item pending", rsp_tdata));
         end else begin
            head = ln_expect_q.pop_front();
            if (rsp_tdata !== head.tdata)
               note_failure($sformatf("x %h terms %0d: expected %h got %h",
                                      head.x, head.terms, head.tdata, rsp_tdata));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [DW-1:0] rd;
      logic [6:0]    terms;
      logic [15:0]   x;
      int            i;
      int            p;
      int            n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register value after reset
      check_term_count();

      // directed table, term count changes only while idle
      for (i = 0; i < NUM_DIR; i++) begin
         if (dir_rows[i].terms != term_setting) set_term_count(dir_rows[i].terms);
         if (dir_rows[i].fixed) begin
            push_x(dir_rows[i].x, {4'h0, dir_rows[i].ln});
         end else begin
            push_x(dir_rows[i].x, {4'h0, ln_series(dir_rows[i].x, term_setting)});
         end
      end

      // random phases
      for (p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES - 1) idle_en = 1'b0;   // clean run at the end
         if (phase_terms[p] < 0) begin
            terms = 7'($urandom_range(0, 127));
         end else begin
            terms = 7'(phase_terms[p]);
         end
         set_term_count(terms);
         // write to the empty index must leave the term count alone
         if (p == 4) begin
            csr_access(1'b1, ADDR_SPARE, $urandom(), rd);
            check_term_count();
         end
         // short latency phases: stall results so the block backs up
         if (p == 0 || p == 2) hold_off_req = 1'b1;
         for (n = 0; n < phase_items[p]; n++) begin
            x = rand_x();
            push_x(x, {4'h0, ln_series(x, term_setting)});
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ln_expect_q.size() != 0)
         note_failure($sformatf("%0d results never arrived", ln_expect_q.size()));

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
src/lse_pkg.sv
src/lse_ctrl.sv
src/lse_dpath.sv
src/log_series_evaluator_unit.sv
dv/testbench.sv
